// File: rtl/tsce_pkg.sv
// ----------------------------------------------------------------------------
// tsce_pkg
// Shared types and constants of the tar stream content extractor.
// ----------------------------------------------------------------------------
package tsce_pkg;

    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 33;
    localparam int BLK_W      = 9;
    localparam int BLOCK_BYTES = 512;

    localparam logic [BLK_W-1:0] SIZE_FIRST = 9'd124;
    localparam logic [BLK_W-1:0] SIZE_LAST  = 9'd134;
    localparam logic [BLK_W-1:0] HDR_LAST   = 9'd511;

    localparam logic [4:0] OCT_DIGIT_HI = 5'b00110;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_byte_xfer;

endpackage

// File: rtl/tsce_front.sv
// ----------------------------------------------------------------------------
// tsce_front
// Classifies each incoming byte as header, content or padding, decodes the
// octal size field and pushes content bytes into the queue.
// ----------------------------------------------------------------------------
module tsce_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [tsce_pkg::BYTE_W-1:0]  i_in_byte,
    output tsce_pkg::t_byte_xfer         o_push
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CONTENT = 2'd1;
    localparam logic [1:0] PH_PAD     = 2'd2;

    logic [1:0]                      r_phase,        n_phase;
    logic [tsce_pkg::BLK_W-1:0]      r_hdr_cnt,      n_hdr_cnt;
    logic [tsce_pkg::SIZE_W-1:0]     r_content_left, n_content_left;
    logic [tsce_pkg::BLK_W-1:0]      r_pad_left,     n_pad_left;
    logic [tsce_pkg::SIZE_W-1:0]     r_size_accum,   n_size_accum;
    logic                            r_size_valid,   n_size_valid;

    logic [tsce_pkg::SIZE_W-1:0]     v_acc;
    logic                            v_vld;
    logic [tsce_pkg::BLK_W-1:0]      v_pad;
    logic                            v_digit;
    logic                            v_in_field;

    assign v_digit    = (i_in_byte[7:3] == tsce_pkg::OCT_DIGIT_HI);
    assign v_in_field = (r_hdr_cnt >= tsce_pkg::SIZE_FIRST) &&
                        (r_hdr_cnt <= tsce_pkg::SIZE_LAST);

    always_comb begin
        n_phase        = r_phase;
        n_hdr_cnt      = r_hdr_cnt;
        n_content_left = r_content_left;
        n_pad_left     = r_pad_left;
        n_size_accum   = r_size_accum;
        n_size_valid   = r_size_valid;
        o_push.valid   = 1'b0;
        o_push.data    = i_in_byte;
        v_acc          = r_size_accum;
        v_vld          = r_size_valid;
        v_pad          = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_CONTENT: begin
                    o_push.valid   = 1'b1;
                    n_content_left = r_content_left - 1'b1;
                    if (r_content_left == tsce_pkg::SIZE_W'(1)) begin
                        n_phase = (r_pad_left != '0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    n_pad_left = r_pad_left - 1'b1;
                    if (r_pad_left == tsce_pkg::BLK_W'(1)) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (r_hdr_cnt == '0) begin
                        v_acc = '0;
                        v_vld = 1'b0;
                    end
                    if (v_in_field) begin
                        if (r_hdr_cnt == tsce_pkg::SIZE_FIRST) begin
                            v_acc = '0;
                            v_vld = 1'b1;
                        end
                        if (v_vld) begin
                            if (!v_digit) begin
                                v_vld = 1'b0;
                            end else if (v_acc[32:30] != 3'b000) begin
                                v_acc = '1;
                            end else begin
                                v_acc = {v_acc[29:0], 3'b000} +
                                        {30'b0, i_in_byte[2:0]};
                            end
                        end
                    end
                    if (r_hdr_cnt == tsce_pkg::HDR_LAST) begin
                        v_pad          = tsce_pkg::BLK_W'(0) - v_acc[tsce_pkg::BLK_W-1:0];
                        n_hdr_cnt      = '0;
                        n_size_valid   = 1'b0;
                        n_size_accum   = v_acc;
                        n_content_left = v_acc;
                        n_pad_left     = v_pad;
                        if (v_acc != '0) begin
                            n_phase = PH_CONTENT;
                        end else if (v_pad != '0) begin
                            n_phase = PH_PAD;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end else begin
                        n_hdr_cnt    = r_hdr_cnt + 1'b1;
                        n_size_accum = v_acc;
                        n_size_valid = v_vld;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_hdr_cnt      <= '0;
            r_content_left <= '0;
            r_pad_left     <= '0;
            r_size_accum   <= '0;
            r_size_valid   <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_hdr_cnt      <= n_hdr_cnt;
            r_content_left <= n_content_left;
            r_pad_left     <= n_pad_left;
            r_size_accum   <= n_size_accum;
            r_size_valid   <= n_size_valid;
        end
    end

endmodule

// File: rtl/tsce_queue.sv
// ----------------------------------------------------------------------------
// tsce_queue
// Short byte queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module tsce_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsce_pkg::t_byte_xfer  i_push,
    input  logic                  i_pop,
    output tsce_pkg::t_byte_xfer  o_head,
    output logic                  o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [tsce_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]            r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]            r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]            r_count,  n_count;
    logic                        v_do_push;
    logic                        v_do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];
    assign v_do_push   = i_push.valid && !o_full;
    assign v_do_pop    = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (v_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (v_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (v_do_push && !v_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!v_do_push && v_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: rtl/tsce_back.sv
// ----------------------------------------------------------------------------
// tsce_back
// Output register: takes content bytes from the queue and presents them.
// ----------------------------------------------------------------------------
module tsce_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tsce_pkg::t_byte_xfer         i_head,
    output logic                         o_pop,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [tsce_pkg::BYTE_W-1:0]  o_out_byte
);

    logic                        r_valid;
    logic [tsce_pkg::BYTE_W-1:0] r_data;
    logic                        v_load;

    assign v_load     = !r_valid || !i_stall;
    assign o_pop      = v_load && i_head.valid;
    assign o_valid    = r_valid;
    assign o_out_byte = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (v_load) begin
            r_valid <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head.data;
        end
    end

endmodule

// File: rtl/tar_stream_content_extractor.sv
// ----------------------------------------------------------------------------
// tar_stream_content_extractor
// Deframes a ustar archive byte stream and passes member content bytes.
// ----------------------------------------------------------------------------
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+------------
//   input    | i_valid  | o_stall  | i_in_byte
//   output   | o_valid  | i_stall  | o_out_byte
//
// One byte is taken per cycle while o_stall is low; header and padding bytes yield no output.
// A content byte passes the combinational classifier, is written into the queue
// and is then loaded into the output register.
// o_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Reset is synchronous; no clearing pass, the block is ready right after.
// ----------------------------------------------------------------------------
module tar_stream_content_extractor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [tsce_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [tsce_pkg::BYTE_W-1:0]  o_out_byte
);

    tsce_pkg::t_byte_xfer w_push;
    tsce_pkg::t_byte_xfer w_head;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_accept;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    tsce_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in_byte),
        .o_push    (w_push)
    );

    tsce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    tsce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte)
    );

endmodule

// File: rtl/tsce_checker.sv
// ----------------------------------------------------------------------------
// tsce_checker
// Port-level checks of the tar stream content extractor.
// ----------------------------------------------------------------------------
module tsce_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_stall,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [tsce_pkg::BYTE_W-1:0]  o_out_byte
);

    logic [31:0] r_in_cnt;
    logic [31:0] r_out_cnt;
    logic        v_in_xact;
    logic        v_out_xact;

    assign v_in_xact  = i_valid && !o_stall;
    assign v_out_xact = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            if (v_in_xact && (r_in_cnt != '1)) begin
                r_in_cnt <= r_in_cnt + 1'b1;
            end
            if (v_out_xact && (r_out_cnt != '1)) begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end
        end
    end

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stalled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte))
        else $error("stalled output transaction changed");

    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_in_cnt > 32'(tsce_pkg::BLOCK_BYTES))
        else $error("output before a full header was taken");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_out_cnt + 32'(tsce_pkg::BLOCK_BYTES) < r_in_cnt)
        else $error("more output transactions than content bytes taken");

endmodule

bind tar_stream_content_extractor tsce_checker u_tsce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_byte (o_out_byte)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of tar_stream_content_extractor. Builds a short tar archive byte
// by byte (header blocks with chosen octal size fields, member content,
// padding) and runs it through the block with random gaps on the input and
// random stall on the output. A byte-level deframer in the testbench predicts
// every content byte. Each output transaction is matched in order.
// ----------------------------------------------------------------------------
module tb;

    typedef enum logic [1:0] {
        STG_HEADER = 2'd0,
        STG_BODY   = 2'd1,
        STG_FILL   = 2'd2
    } t_stage;

    localparam logic [tsce_pkg::BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [tsce_pkg::BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [tsce_pkg::BYTE_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [tsce_pkg::BYTE_W-1:0] CH_EIGHT = 8'h38;
    localparam logic [tsce_pkg::SIZE_W-1:0] SIZE_SAT = '1;
    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int unsigned FIRST_SIZE = 88;
    localparam int unsigned TAIL_SIZE = 40;

    logic                        i_clk;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [tsce_pkg::BYTE_W-1:0] i_in_byte = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [tsce_pkg::BYTE_W-1:0] o_out_byte;

    // deframer state
    t_stage                      stage     = STG_HEADER;
    logic [tsce_pkg::BLK_W-1:0]  hdr_pos   = '0;
    logic [tsce_pkg::SIZE_W-1:0] body_left = '0;
    logic [tsce_pkg::BLK_W-1:0]  fill_left = '0;
    logic [tsce_pkg::SIZE_W-1:0] size_acc  = '0;
    logic                        size_live = 1'b0;

    logic [tsce_pkg::BYTE_W-1:0] content_bytes_due [$];
    logic [tsce_pkg::BYTE_W-1:0] size_chars [0:10];
    int unsigned                 err_count = 0;
    int unsigned                 cycles = 0;
    int unsigned                 tx_gap_pct = 0;
    int unsigned                 rx_stall_pct = 0;
    int unsigned                 stall_run = 0;

    tar_stream_content_extractor uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_byte  (i_in_byte),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit deframe_byte(input logic [tsce_pkg::BYTE_W-1:0] b);
        logic [tsce_pkg::SIZE_W+2:0] grown;
        bit                          is_body;
        is_body = 1'b0;
        case (stage)
            STG_BODY: begin
                is_body = 1'b1;
                body_left = body_left - 1'b1;
                if (body_left == '0) begin
                    stage = (fill_left != '0) ? STG_FILL : STG_HEADER;
                end
            end
            STG_FILL: begin
                fill_left = fill_left - 1'b1;
                if (fill_left == '0) begin
                    stage = STG_HEADER;
                end
            end
            default: begin
                stage = STG_HEADER;
                if (hdr_pos == '0) begin
                    size_acc = '0;
                    size_live = 1'b0;
                end
                if (hdr_pos >= tsce_pkg::SIZE_FIRST && hdr_pos <= tsce_pkg::SIZE_LAST) begin
                    if (hdr_pos == tsce_pkg::SIZE_FIRST) begin
                        size_acc = '0;
                        size_live = 1'b1;
                    end
                    if (size_live) begin
                        if (b < CH_ZERO || b > CH_SEVEN) begin
                            size_live = 1'b0;
                        end else begin
                            grown = {size_acc, 3'b000} +
                                    (tsce_pkg::SIZE_W+3)'(b - CH_ZERO);
                            size_acc = (grown > SIZE_SAT) ? SIZE_SAT
                                                          : grown[tsce_pkg::SIZE_W-1:0];
                        end
                    end
                end
                if (hdr_pos == tsce_pkg::HDR_LAST) begin
                    hdr_pos = '0;
                    size_live = 1'b0;
                    body_left = size_acc;
                    fill_left = -size_acc[tsce_pkg::BLK_W-1:0];
                    if (body_left != '0) begin
                        stage = STG_BODY;
                    end else if (fill_left != '0) begin
                        stage = STG_FILL;
                    end
                end else begin
                    hdr_pos = hdr_pos + 1'b1;
                end
            end
        endcase
        return is_body;
    endfunction

    // drive one byte, hold it until accepted, then predict
    task automatic push_byte(input logic [tsce_pkg::BYTE_W-1:0] b);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (deframe_byte(b)) begin
            content_bytes_due.push_back(b);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (content_bytes_due.size() != 0);
    endtask

    // digits: number of field characters written as octal; stop follows them
    task automatic fill_size_field(input longint unsigned size, input int digits,
                                   input logic [tsce_pkg::BYTE_W-1:0] stop);
        longint unsigned v;
        v = size;
        for (int i = 0; i < 11; i++) size_chars[i] = 8'($urandom_range(0, 255));
        for (int i = digits - 1; i >= 0; i--) begin
            size_chars[i] = CH_ZERO + 8'(v & 64'd7);
            v = v >> 3;
        end
        if (digits < 11) size_chars[digits] = stop;
    endtask

    task automatic send_header(input longint unsigned size, input int digits,
                               input logic [tsce_pkg::BYTE_W-1:0] stop);
        logic [tsce_pkg::BYTE_W-1:0] b;
        fill_size_field(size, digits, stop);
        for (int p = 0; p < tsce_pkg::BLOCK_BYTES; p++) begin
            if (p >= tsce_pkg::SIZE_FIRST && p <= tsce_pkg::SIZE_LAST) begin
                b = size_chars[p - tsce_pkg::SIZE_FIRST];
            end else if ((p == tsce_pkg::SIZE_FIRST - 1 || p == tsce_pkg::SIZE_LAST + 1) &&
                         $urandom_range(0, 1)) begin
                b = CH_SEVEN;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            push_byte(b);
        end
    endtask

    task automatic send_body(input int unsigned count);
        repeat (count) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_stopped_size_field();
        tx_gap_pct = 20;
        rx_stall_pct = 20;
        // digit 8 halts accumulation after three octal digits
        send_header(FIRST_SIZE, 3, CH_EIGHT);
    endtask

    task automatic test_content_pressure();
        tx_gap_pct = 20;
        rx_stall_pct = 40;
        send_body(FIRST_SIZE);
        wait_drained();
    endtask

    task automatic test_padding_drop();
        tx_gap_pct = 10;
        rx_stall_pct = 20;
        while (stage != STG_HEADER) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_steady_tail();
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        send_header(TAIL_SIZE, 11, CH_NUL);
        send_body(TAIL_SIZE);
    endtask

    // output side: stall bursts and in-order compare
    always @(posedge i_clk) begin
        logic [tsce_pkg::BYTE_W-1:0] due;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (content_bytes_due.size() == 0) begin
                    $display("%0t: unexpected content byte: expected none, actual %02h",
                             $time, o_out_byte);
                    err_count++;
                end else begin
                    due = content_bytes_due.pop_front();
                    if (o_out_byte !== due) begin
                        $display("%0t: content byte mismatch: expected %02h, actual %02h",
                                 $time, due, o_out_byte);
                        err_count++;
                    end
                end
            end
            if (stall_run != 0) begin
                stall_run--;
                i_stall <= 1'b1;
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                stall_run = $urandom_range(1, 8) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tar_stream_content_extractor verification failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stopped_size_field();
        test_content_pressure();
        test_padding_drop();
        test_steady_tail();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && content_bytes_due.size() == 0) begin
            $display("tar_stream_content_extractor verification clean");
        end else begin
            $display("tar_stream_content_extractor verification failed");
        end
        $finish;
    end

endmodule
